// File: src/b2s_pkg.sv
// Package for the keyed BLAKE2s stream hasher.
// Holds IV, message schedule, G column indexes and state codes; no dependencies.
package b2s_pkg;

   localparam logic [31:0] IV [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic [3:0] SIGMA [10][16] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
      '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
        4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
      '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
        4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
      '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
        4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
      '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
        4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
      '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
        4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
      '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
        4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
      '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
        4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
      '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
        4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
   };

   localparam logic [3:0] COL_B [8] = '{4'd4, 4'd5, 4'd6, 4'd7, 4'd5, 4'd6, 4'd7, 4'd4};
   localparam logic [3:0] COL_C [8] = '{4'd8, 4'd9, 4'd10, 4'd11, 4'd10, 4'd11, 4'd8, 4'd9};
   localparam logic [3:0] COL_D [8] = '{4'd12, 4'd13, 4'd14, 4'd15, 4'd15, 4'd12, 4'd13, 4'd14};

   // Register indexes on the CSR port.
   localparam logic [2:0] REG_DIGEST_LEN = 3'd0;
   localparam logic [2:0] REG_KEY0       = 3'd1;
   localparam logic [2:0] REG_KEY1       = 3'd2;
   localparam logic [2:0] REG_KEY2       = 3'd3;
   localparam logic [2:0] REG_KEY3       = 3'd4;
   localparam logic [2:0] REG_CTR_INIT   = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LOAD  = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_FOLD  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
      rotr32 = (x >> n) | (x << (6'd32 - {1'b0, n}));
   endfunction

endpackage

// File: src/blake2s_keyed_hash_stream.sv
// Keyed BLAKE2s stream hasher, top level.
// Depends on b2s_pkg; holds the block buffer, the sequencer and one shared G half-step unit.
//
// Usage:
//  - req_ channel carries one byte transaction (req_data_byte, req_byte_present, req_is_last).
//    Bytes are buffered; a full block is compressed lazily when the next byte arrives.
//  - rsp_ channel returns digest bytes, little endian from the chain value, one per
//    transaction, with rsp_digest_last on the final one.
//  - csr_ port writes digest length, four key words and the counter preset; write only
//    while idle. Values are sampled when a message opens.
//  - Compression: a byte that does not close a block is stored and the block stays idle.
//    A compression runs the load state, 10 rounds x 8 G x 2 halves on the single shared
//    G half-step unit (two adds, two xor-rotates), then the fold state.
//  - Last item: once it is accepted, the buffered block is compressed (after a full block
//    waiting, if the item carries a byte); then the block presents one digest byte per
//    cycle, the digest length in all, unless the receiver stalls.
//  - req_stall is high whenever the block is busy compressing or emitting the digest.
//  - rsp_valid holds with a stable payload while rsp_stall is high; the sequencer waits.
//  - Reset clears control state and loads register defaults (digest length 32, key and
//    counter preset zero); the block buffer contents are undefined until written.
module blake2s_keyed_hash_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_digest_byte,
   output logic        rsp_digest_last,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   // Configuration registers.
   logic [5:0]  dlen_ff;
   logic [63:0] key_ff [4];
   logic [63:0] ctr_init_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dlen_ff     <= 6'd32;
         key_ff[0]   <= '0;
         key_ff[1]   <= '0;
         key_ff[2]   <= '0;
         key_ff[3]   <= '0;
         ctr_init_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            b2s_pkg::REG_DIGEST_LEN: dlen_ff     <= csr_data[5:0];
            b2s_pkg::REG_KEY0:       key_ff[0]   <= csr_data;
            b2s_pkg::REG_KEY1:       key_ff[1]   <= csr_data;
            b2s_pkg::REG_KEY2:       key_ff[2]   <= csr_data;
            b2s_pkg::REG_KEY3:       key_ff[3]   <= csr_data;
            b2s_pkg::REG_CTR_INIT:   ctr_init_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Hash state. The block buffer is kept as 16 little-endian message words.
   b2s_pkg::state_type state_ff;
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [16];
   logic [31:0] buf_ff [16];
   logic [6:0]  fill_ff;
   logic [63:0] cnt_ff;
   logic        open_ff;
   logic [5:0]  len_ff;
   logic        final_ff;
   logic        pend_last_ff; // item also closes the message
   logic [7:0]  pend_byte_ff; // byte waiting to be stored after a lazy compression
   logic [3:0]  round_ff;
   logic [3:0]  step_ff;      // G index in [3:1], half in [0]
   logic [4:0]  out_idx_ff;

   logic accept;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != b2s_pkg::ST_IDLE);

   // Clamp digest length: zero as one, above 32 as 32.
   logic [5:0] dlen_eff;
   always_comb begin
      if (dlen_ff == 6'd0)       dlen_eff = 6'd1;
      else if (dlen_ff > 6'd32)  dlen_eff = 6'd32;
      else                       dlen_eff = dlen_ff;
   end

   // Shared G half-step unit.
   logic [2:0]  gi;
   logic        half;
   logic [3:0]  ia, ib, ic, id, mi;
   logic [31:0] m_word, a1, d1, c1, b1;
   assign gi   = step_ff[3:1];
   assign half = step_ff[0];
   assign ia   = {2'b00, gi[1:0]};
   assign ib   = b2s_pkg::COL_B[gi];
   assign ic   = b2s_pkg::COL_C[gi];
   assign id   = b2s_pkg::COL_D[gi];
   assign mi   = b2s_pkg::SIGMA[round_ff][{gi, half}];
   assign m_word = buf_ff[mi];
   assign a1 = v_ff[ia] + v_ff[ib] + m_word;
   assign d1 = b2s_pkg::rotr32(v_ff[id] ^ a1, half ? 5'd8 : 5'd16);
   assign c1 = v_ff[ic] + d1;
   assign b1 = b2s_pkg::rotr32(v_ff[ib] ^ c1, half ? 5'd7 : 5'd12);

   logic [63:0] cnt_final;
   assign cnt_final = cnt_ff + {57'd0, fill_ff};

   // Last block with every byte at or beyond the fill level dropped to zero.
   logic [31:0] buf_tail [16];
   always_comb begin
      for (int w = 0; w < 16; w++)
         for (int b = 0; b < 4; b++)
            buf_tail[w][b * 8 +: 8] = (7'(w * 4 + b) >= fill_ff) ? 8'h00
                                                                  : buf_ff[w][b * 8 +: 8];
   end

   logic [31:0] out_word;
   assign out_word = h_ff[out_idx_ff[4:2]];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2s_pkg::ST_IDLE;
         open_ff  <= 1'b0;
         fill_ff  <= '0;
      end else begin
         unique case (state_ff)
            b2s_pkg::ST_IDLE: begin
               if (accept) begin
                  logic [6:0] f;
                  f = fill_ff;
                  if (!open_ff) begin
                     // Open the message: parameter block, counter preset, key block.
                     for (int i = 1; i < 8; i++) h_ff[i] <= b2s_pkg::IV[i];
                     h_ff[0] <= b2s_pkg::IV[0] ^ {8'h01, 8'h01, 8'h20, 2'b00, dlen_eff};
                     len_ff  <= dlen_eff;
                     cnt_ff  <= ctr_init_ff;
                     for (int i = 0; i < 8; i++) buf_ff[i] <= key_ff[i / 2][(i % 2) * 32 +: 32];
                     for (int i = 8; i < 16; i++) buf_ff[i] <= 32'h0;
                     open_ff <= 1'b1;
                     f       = 7'd64;
                  end
                  pend_last_ff <= req_is_last;
                  pend_byte_ff <= req_data_byte;
                  if (req_byte_present && f[6]) begin
                     // Block full: compress it first, then store the byte.
                     final_ff <= 1'b0;
                     fill_ff  <= 7'd64;
                     state_ff <= b2s_pkg::ST_LOAD;
                  end else if (req_byte_present) begin
                     buf_ff[f[5:2]][{f[1:0], 3'b000} +: 8] <= req_data_byte;
                     fill_ff <= f + 7'd1;
                     if (req_is_last) begin
                        final_ff <= 1'b1;
                        state_ff <= b2s_pkg::ST_LOAD;
                     end
                  end else begin
                     fill_ff <= f;
                     if (req_is_last) begin
                        final_ff <= 1'b1;
                        state_ff <= b2s_pkg::ST_LOAD;
                     end
                  end
               end
            end
            b2s_pkg::ST_LOAD: begin
               logic [63:0] c;
               c = final_ff ? cnt_final : (cnt_ff + 64'd64);
               cnt_ff <= c;
               if (final_ff) begin
                  // Zero the tail of the last block.
                  for (int i = 0; i < 16; i++) buf_ff[i] <= buf_tail[i];
               end
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
               for (int i = 0; i < 4; i++) v_ff[i + 8] <= b2s_pkg::IV[i];
               v_ff[12] <= b2s_pkg::IV[4] ^ c[31:0];
               v_ff[13] <= b2s_pkg::IV[5] ^ c[63:32];
               v_ff[14] <= b2s_pkg::IV[6] ^ {32{final_ff}};
               v_ff[15] <= b2s_pkg::IV[7];
               round_ff <= '0;
               step_ff  <= '0;
               state_ff <= b2s_pkg::ST_ROUND;
            end
            b2s_pkg::ST_ROUND: begin
               v_ff[ia] <= a1;
               v_ff[ib] <= b1;
               v_ff[ic] <= c1;
               v_ff[id] <= d1;
               step_ff  <= step_ff + 4'd1;
               if (step_ff == 4'd15) begin
                  round_ff <= round_ff + 4'd1;
                  if (round_ff == 4'd9) state_ff <= b2s_pkg::ST_FOLD;
               end
            end
            b2s_pkg::ST_FOLD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] ^ v_ff[i] ^ v_ff[i + 8];
               if (final_ff) begin
                  out_idx_ff <= '0;
                  state_ff   <= b2s_pkg::ST_OUT;
               end else begin
                  // Store the byte that triggered the lazy compression.
                  buf_ff[0][7:0] <= pend_byte_ff;
                  fill_ff        <= 7'd1;
                  if (pend_last_ff) begin
                     final_ff <= 1'b1;
                     state_ff <= b2s_pkg::ST_LOAD;
                  end else begin
                     state_ff <= b2s_pkg::ST_IDLE;
                  end
               end
            end
            b2s_pkg::ST_OUT: begin
               if (!rsp_stall) begin
                  out_idx_ff <= out_idx_ff + 5'd1;
                  if ({1'b0, out_idx_ff} + 6'd1 == len_ff) begin
                     open_ff  <= 1'b0;
                     fill_ff  <= '0;
                     state_ff <= b2s_pkg::ST_IDLE;
                  end
               end
            end
            default: state_ff <= b2s_pkg::ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = (state_ff == b2s_pkg::ST_OUT);
   assign rsp_digest_byte = out_word[{out_idx_ff[1:0], 3'b000} +: 8];
   assign rsp_digest_last = ({1'b0, out_idx_ff} + 6'd1 == len_ff);

endmodule
